// ----- sv/fwrm_pkg.sv -----
// ----------------------------------------------------------------------------
// fwrm_pkg
// Shared types and codes of the queue with largest-entry extraction.
// ----------------------------------------------------------------------------
package fwrm_pkg;

  localparam int DATA_W = 32;

  // Function selector codes.
  localparam logic [2:0] FN_ENQ      = 3'd0;
  localparam logic [2:0] FN_DEQ      = 3'd1;
  localparam logic [2:0] FN_DEQ_MAX  = 3'd2;
  localparam logic [2:0] FN_PEEK     = 3'd3;
  localparam logic [2:0] FN_PEEK_MAX = 3'd4;
  localparam logic [2:0] FN_CLEAR    = 3'd5;

  // Status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic enq;    // write the word into the cell at the fill position
    logic shift;  // cells at or behind the removal position take their neighbor
  } cell_cmd_t;

endpackage

// ----- sv/fwrm_if.sv -----
// ----------------------------------------------------------------------------
// fwrm_if
// Valid/ready channels for the queue: command words in, response words out.
// ----------------------------------------------------------------------------
interface fwrm_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [31:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface fwrm_rsp_if #(
  parameter int CW = 5
);
  logic               valid;
  logic               ready;
  logic signed [31:0] data;
  logic [CW-1:0]      occupancy;
  logic [1:0]         status;

  modport source (output valid, output data, output occupancy, output status, input ready);
  modport sink   (input valid, input data, input occupancy, input status, output ready);
endinterface

// ----- sv/fifo_with_remove_max_core.sv -----
// ----------------------------------------------------------------------------
// fifo_with_remove_max_core
// Ordered queue of signed words with dequeue/peek of the front or the largest.
// Enqueue, dequeue, peek, clear: the response is registered and appears in the cycle after acceptance.
// Dequeue-max, peek-max: the search token walks the cell chain to the last cell
// before the response; one command is in flight at a time.
// Reset (synchronous) empties the queue and drops any pending response.
// ----------------------------------------------------------------------------
module fifo_with_remove_max_core import fwrm_pkg::*; #(
  parameter int DEPTH = 16,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int IW = $clog2(DEPTH)
) (
  input  logic         clk,
  input  logic         rst,
  fwrm_cmd_if.sink     cmd,
  fwrm_rsp_if.source   rsp
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      scan_cnt;
  logic               scan_deq;
  logic               out_valid;
  logic signed [31:0] out_data;
  logic [CW-1:0]      out_occ;
  logic [1:0]         out_status;

  logic               accept;
  logic               scan_done;
  logic               load_out;
  logic signed [31:0] res_data;
  logic [1:0]         res_status;
  cell_cmd_t          cell_cmd;
  logic [IW-1:0]      shift_pos;

  logic signed [DATA_W-1:0] cell_value [DEPTH];
  logic signed [DATA_W-1:0] cell_next  [DEPTH];
  logic                     tok_have   [DEPTH+1];
  logic signed [DATA_W-1:0] tok_val    [DEPTH+1];
  logic [IW-1:0]            tok_idx    [DEPTH+1];

  assign tok_have[0] = 1'b0;
  assign tok_val[0]  = '0;
  assign tok_idx[0]  = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i < DEPTH - 1) begin : g_mid
      assign cell_next[i] = cell_value[i+1];
    end else begin : g_last
      assign cell_next[i] = cell_value[i];
    end

    fwrm_cell #(
      .DEPTH (DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cell_cmd),
      .count      (count),
      .pos        (shift_pos),
      .wdata      (cmd.value),
      .next_value (cell_next[i]),
      .value      (cell_value[i]),
      .have_in    (tok_have[i]),
      .val_in     (tok_val[i]),
      .idx_in     (tok_idx[i]),
      .have_out   (tok_have[i+1]),
      .val_out    (tok_val[i+1]),
      .idx_out    (tok_idx[i+1])
    );
  end

  assign cmd.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = cmd.valid && cmd.ready;
  // The search is complete once the token has passed out of the last cell.
  assign scan_done = (state == S_SCAN) && (scan_cnt == CW'(DEPTH));

  always_comb begin
    state_next = state;
    count_next = count;
    cell_cmd   = '0;
    shift_pos  = '0;
    load_out   = 1'b0;
    res_data   = '0;
    res_status = STAT_OK;
    if (accept) begin
      case (cmd.func) inside
        FN_ENQ: begin
          load_out = 1'b1;
          if (count == CW'(DEPTH)) begin
            res_status = STAT_FULL;
          end else begin
            cell_cmd.enq = 1'b1;
            count_next   = count + CW'(1);
          end
        end
        FN_DEQ, FN_PEEK: begin
          load_out = 1'b1;
          if (count == '0) begin
            res_status = STAT_EMPTY;
          end else begin
            res_data = cell_value[0];
            if (cmd.func == FN_DEQ) begin
              cell_cmd.shift = 1'b1;
              count_next     = count - CW'(1);
            end
          end
        end
        FN_DEQ_MAX, FN_PEEK_MAX: begin
          if (count == '0) begin
            load_out   = 1'b1;
            res_status = STAT_EMPTY;
          end else begin
            state_next = S_SCAN;
          end
        end
        FN_CLEAR: begin
          load_out   = 1'b1;
          count_next = '0;
        end
        default: begin
          load_out = 1'b1;
        end
      endcase
    end else if (scan_done) begin
      load_out   = 1'b1;
      state_next = S_IDLE;
      res_data   = tok_val[DEPTH];
      if (scan_deq) begin
        cell_cmd.shift = 1'b1;
        shift_pos      = tok_idx[DEPTH];
        count_next     = count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      scan_cnt  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_SCAN) begin
        scan_cnt <= scan_cnt + CW'(1);
      end else begin
        scan_cnt <= '0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scan_deq <= (cmd.func == FN_DEQ_MAX);
    end
    if (load_out) begin
      out_data   <= res_data;
      out_occ    <= count_next;
      out_status <= res_status;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.data      = out_data;
  assign rsp.occupancy = out_occ;
  assign rsp.status    = out_status;

endmodule

// ----- sv/fwrm_cell.sv -----
// ----------------------------------------------------------------------------
// fwrm_cell
// One queue slot. Holds its entry, takes the entry behind it on a removal, and
// forwards a running largest-value token one cell per cycle during a search.
// ----------------------------------------------------------------------------
module fwrm_cell import fwrm_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int INDEX = 0,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int IW = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic [CW-1:0]            count,
  input  logic [IW-1:0]            pos,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic signed [DATA_W-1:0] next_value,
  output logic signed [DATA_W-1:0] value,
  input  logic                     have_in,
  input  logic signed [DATA_W-1:0] val_in,
  input  logic [IW-1:0]            idx_in,
  output logic                     have_out,
  output logic signed [DATA_W-1:0] val_out,
  output logic [IW-1:0]            idx_out
);

  logic occupied;
  logic take;

  assign occupied = CW'(INDEX) < count;
  // Strictly greater keeps the earliest of equal maxima.
  assign take     = occupied && (!have_in || (value > val_in));

  always_ff @(posedge clk) begin
    if (cmd.enq && (count == CW'(INDEX))) begin
      value <= wdata;
    end else if (cmd.shift && (IW'(INDEX) >= pos)) begin
      value <= next_value;
    end
  end

  always_ff @(posedge clk) begin
    have_out <= have_in || occupied;
    if (take) begin
      val_out <= value;
      idx_out <= IW'(INDEX);
    end else begin
      val_out <= val_in;
      idx_out <= idx_in;
    end
  end

endmodule
